// ===== hdl/dss_pkg.sv =====
// Package with the types, codes and defaults shared by the disk seek scheduler files.
package dss_pkg;

   // Fixed widths of the transfer fields.
   localparam int TRACK_W = 16;
   localparam int CSR_W   = 16;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_REQUESTS = 32;
   localparam int DEF_TRACK_BITS   = 16;

   // Scheduling modes.
   localparam logic [1:0] MODE_FCFS  = 2'd0;
   localparam logic [1:0] MODE_SSTF  = 2'd1;
   localparam logic [1:0] MODE_SCAN  = 2'd2;
   localparam logic [1:0] MODE_CSCAN = 2'd3;

   // Register indexes.
   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_START = 1'b1;

   typedef struct packed {
      logic [TRACK_W-1:0] request_track;
      logic               last_request;
   } req_type;

   typedef struct packed {
      logic [TRACK_W-1:0] served_track;
      logic [TRACK_W-1:0] seek_distance;
      logic               end_of_order;
   } rsp_type;

   // Controls from the sequencer to one cell.
   typedef struct packed {
      logic load;
      logic shift;
      logic clear_served;
      logic mark;
   } cell_ctl_type;

endpackage

// ===== hdl/dss_cell.sv =====
// One cell of the request ring: a stored track and its served flag.
module dss_cell #(
   parameter int TRACK_BITS = dss_pkg::DEF_TRACK_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dss_pkg::cell_ctl_type  ctl,
   input  logic [TRACK_BITS-1:0]  load_track,
   input  logic [TRACK_BITS-1:0]  next_track,
   input  logic                   next_served,
   output logic [TRACK_BITS-1:0]  track,
   output logic                   served
);
   import dss_pkg::*;

   logic [TRACK_BITS-1:0] track_ff, track_in;
   logic                  served_ff, served_in;

   // A load writes the track; a shift takes the neighbour's contents.
   always_comb begin
      track_in  = track_ff;
      served_in = served_ff;
      if (ctl.load) begin
         track_in = load_track;
      end else if (ctl.shift) begin
         track_in  = next_track;
         served_in = next_served;
      end
      if (ctl.clear_served) begin
         served_in = 1'b0;
      end else if (ctl.mark) begin
         served_in = 1'b1;
      end
   end

   // The track needs no reset; the served flag does.
   always_ff @(posedge clock) begin
      track_ff <= track_in;
      if (reset) begin
         served_ff <= 1'b0;
      end else begin
         served_ff <= served_in;
      end
   end

   assign track  = track_ff;
   assign served = served_ff;

endmodule

// ===== hdl/disk_seek_scheduler.sv =====
// Top level of the disk seek scheduler: request ring, sequencer and result register.
// Requests load one per cycle, while busy is low, into a ring of MAX_REQUESTS cells. The item
// carrying last_request starts scheduling and busy rises. For each of the n stored requests
// the ring rotates once past a single key comparator, then a result state marks the winner
// and issues its result; results appear one per pass, each strobed by rsp_valid for one
// cycle and not held, with end_of_order on the final one. The user must write the
// configuration through csr_we, csr_index and csr_wdata only while busy is low; the
// block itself does not enforce it.
module disk_seek_scheduler #(
   parameter int MAX_REQUESTS = dss_pkg::DEF_MAX_REQUESTS,
   parameter int TRACK_BITS   = dss_pkg::DEF_TRACK_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  dss_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output dss_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [dss_pkg::CSR_W-1:0]      csr_wdata
);
   import dss_pkg::*;

   localparam int IDX_BITS = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);
   localparam int KEY_BITS = ((TRACK_BITS > IDX_BITS) ? TRACK_BITS : IDX_BITS) + 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PASS = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            mode_ff, mode_in;
   logic [TRACK_BITS-1:0] start_ff, start_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   emitted_ff, emitted_in;
   logic [IDX_BITS-1:0]   slot_ff, slot_in;
   logic [TRACK_BITS-1:0] head_ff, head_in;
   logic                  found_ff, found_in;
   logic [KEY_BITS-1:0]   best_key_ff, best_key_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [TRACK_BITS-1:0] best_trk_ff, best_trk_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   cell_ctl_type          cell_ctl [MAX_REQUESTS];
   logic [TRACK_BITS-1:0] cell_trk [MAX_REQUESTS];
   logic                  cell_srv [MAX_REQUESTS];

   logic                  accept;
   logic [TRACK_BITS-1:0] new_trk;
   logic [TRACK_BITS-1:0] trk0;
   logic [TRACK_BITS-1:0] dist0;
   logic [TRACK_BITS-1:0] best_dist;
   logic                  above;
   logic                  cand;
   logic [KEY_BITS-1:0]   key0;

   assign accept  = start && !busy;
   assign new_trk = TRACK_BITS'(req_data.request_track);
   assign trk0    = cell_trk[0];

   // Ring of cells; each rotates towards cell zero.
   for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
      always_comb begin
         cell_ctl[g].load         = accept && (count_ff < CNT_BITS'(MAX_REQUESTS)) &&
                                    (count_ff == CNT_BITS'(g));
         cell_ctl[g].shift        = (state_ff == ST_PASS);
         cell_ctl[g].clear_served = accept && req_data.last_request;
         cell_ctl[g].mark         = (state_ff == ST_EMIT) && (best_idx_ff == IDX_BITS'(g));
      end
      dss_cell #(
         .TRACK_BITS(TRACK_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[g]),
         .load_track (new_trk),
         .next_track (cell_trk[(g + 1) % MAX_REQUESTS]),
         .next_served(cell_srv[(g + 1) % MAX_REQUESTS]),
         .track      (cell_trk[g]),
         .served     (cell_srv[g])
      );
   end

   // Ordering key of the entry now at the comparator; the lowest key wins, and the
   // earliest slot wins a tie because a pass always starts at slot zero.
   always_comb begin
      dist0 = (trk0 > head_ff) ? (trk0 - head_ff) : (head_ff - trk0);
      above = trk0 > start_ff;
      cand  = (CNT_BITS'(slot_ff) < count_ff) && !cell_srv[0];
      unique case (mode_ff)
         MODE_FCFS:  key0 = KEY_BITS'(slot_ff);
         MODE_SSTF:  key0 = KEY_BITS'(dist0);
         MODE_SCAN:  key0 = KEY_BITS'({!above, (above ? trk0 : ~trk0)});
         MODE_CSCAN: key0 = KEY_BITS'({!above, trk0});
         default:    key0 = KEY_BITS'(slot_ff);
      endcase
   end

   assign best_dist = (best_trk_ff > head_ff) ? (best_trk_ff - head_ff)
                                              : (head_ff - best_trk_ff);

   // Sequencer: load, one comparison pass per result, then the result itself.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      emitted_in   = emitted_ff;
      slot_in      = slot_ff;
      head_in      = head_ff;
      found_in     = found_ff;
      best_key_in  = best_key_ff;
      best_idx_in  = best_idx_ff;
      best_trk_in  = best_trk_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_MODE:  mode_in  = csr_wdata[1:0];
            REG_START: start_in = TRACK_BITS'(csr_wdata);
            default:   mode_in  = mode_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff < CNT_BITS'(MAX_REQUESTS)) begin
                  count_in = count_ff + CNT_BITS'(1);
               end
               if (req_data.last_request) begin
                  state_in   = ST_PASS;
                  head_in    = start_ff;
                  emitted_in = '0;
                  slot_in    = '0;
                  found_in   = 1'b0;
               end
            end
         end
         ST_PASS: begin
            if (cand && (!found_ff || (key0 < best_key_ff))) begin
               found_in    = 1'b1;
               best_key_in = key0;
               best_idx_in = slot_ff;
               best_trk_in = trk0;
            end
            slot_in = slot_ff + IDX_BITS'(1);
            if (slot_ff == IDX_BITS'(MAX_REQUESTS - 1)) begin
               slot_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.served_track   = TRACK_W'(best_trk_ff);
            rsp_data_in.seek_distance  = TRACK_W'(best_dist);
            rsp_data_in.end_of_order   = (emitted_ff + CNT_BITS'(1) == count_ff);
            head_in    = best_trk_ff;
            emitted_in = emitted_ff + CNT_BITS'(1);
            found_in   = 1'b0;
            slot_in    = '0;
            if (emitted_ff + CNT_BITS'(1) == count_ff) begin
               state_in = ST_IDLE;
               count_in = '0;
            end else begin
               state_in = ST_PASS;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers take reset; payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_FCFS;
         start_ff     <= '0;
         count_ff     <= '0;
         emitted_ff   <= '0;
         slot_ff      <= '0;
         head_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         emitted_ff   <= emitted_in;
         slot_ff      <= slot_in;
         head_ff      <= head_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      best_trk_ff <= best_trk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result follows only a result cycle of the sequencer.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("result without a result cycle");

   // The fill count never passes the ring depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_REQUESTS))
      else $error("request count beyond ring depth");

   // Every pass that reaches a result cycle has found an unserved entry.
   a_found_at_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> found_ff)
      else $error("result cycle without a candidate");

   // Scheduling never runs on an empty batch.
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff != '0))
      else $error("scheduling an empty batch");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the disk seek scheduler: directed and random request batches in all modes.
module tb_top;
   import dss_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH   = DEF_MAX_REQUESTS;
   localparam int SETTLE  = DEPTH * (DEPTH + 1) + 20;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;

   // Items waiting to be driven, and results still to come.
   req_type          pending_reqs[$];
   rsp_type          awaited_order[$];

   // Shadow of the configuration and of the batch being collected.
   logic [1:0]       mode_shadow;
   logic [15:0]      start_shadow;
   logic [15:0]      batch_tracks[$];

   int               error_count;
   int               transfer_count;
   req_type          taken;

   disk_seek_scheduler uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out the service order of the collected batch and queues its results.
   task automatic predict_service_order();
      logic [15:0] order[$];
      logic [15:0] sorted[$];
      bit          served[$];
      logic [15:0] head;
      int          n, locate, best, bestd, d;
      rsp_type     r;
      n = batch_tracks.size();
      head = start_shadow;
      if (mode_shadow == MODE_FCFS) begin
         order = batch_tracks;
      end else if (mode_shadow == MODE_SSTF) begin
         for (int i = 0; i < n; i++) served.push_back(1'b0);
         for (int k = 0; k < n; k++) begin
            best = -1;
            bestd = 0;
            for (int j = 0; j < n; j++) begin
               if (!served[j]) begin
                  d = (batch_tracks[j] > head) ? batch_tracks[j] - head : head - batch_tracks[j];
                  if (best < 0 || d < bestd) begin
                     best = j;
                     bestd = d;
                  end
               end
            end
            served[best] = 1'b1;
            order.push_back(batch_tracks[best]);
            head = batch_tracks[best];
         end
         head = start_shadow;
      end else begin
         sorted = batch_tracks;
         sorted.sort();
         locate = 0;
         while (locate < n && sorted[locate] <= head) locate++;
         if (mode_shadow == MODE_SCAN) begin
            for (int i = locate; i < n; i++) order.push_back(sorted[i]);
            for (int i = locate; i > 0; i--) order.push_back(sorted[i-1]);
         end else begin
            for (int i = 0; i < n; i++) order.push_back(sorted[(i + locate) % n]);
         end
      end
      // Seek distances follow the head from the start track.
      foreach (order[k]) begin
         r.served_track  = order[k];
         r.seek_distance = (order[k] > head) ? order[k] - head : head - order[k];
         r.end_of_order  = (k == n - 1);
         awaited_order.push_back(r);
         head = order[k];
      end
      batch_tracks.delete();
   endtask

   // Driver: one transfer per accepted item, random gaps except in a calm stretch.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            taken = pending_reqs.pop_front();
            transfer_count++;
            if (batch_tracks.size() < DEPTH) batch_tracks.push_back(taken.request_track);
            if (taken.last_request) predict_service_order();
         end
         if (!(start && busy)) begin
            if (pending_reqs.size() > 0 &&
                ((transfer_count >= 60 && transfer_count < 110) ||
                 $urandom_range(99) >= 31)) begin
               start    <= 1'b1;
               req_data <= pending_reqs[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_order.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Unexpected result: track %0d distance %0d end %0b",
                        rsp_data.served_track, rsp_data.seek_distance, rsp_data.end_of_order);
         end else begin
            if (rsp_data.served_track  !== awaited_order[0].served_track ||
                rsp_data.seek_distance !== awaited_order[0].seek_distance ||
                rsp_data.end_of_order  !== awaited_order[0].end_of_order) begin
               error_count++;
               if (error_count <= 10)
                  $display("Mismatch: expected track %0d dist %0d end %0b, got %0d %0d %0b",
                           awaited_order[0].served_track, awaited_order[0].seek_distance,
                           awaited_order[0].end_of_order, rsp_data.served_track,
                           rsp_data.seek_distance, rsp_data.end_of_order);
            end
            void'(awaited_order.pop_front());
         end
      end
   end

   task automatic write_reg(input logic idx, input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_MODE) mode_shadow = value[1:0];
      else start_shadow = value;
   endtask

   // Waits until every item is taken and every result has come, then lets the block settle.
   task automatic drain();
      while (pending_reqs.size() > 0 || start || awaited_order.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic queue_req(input logic [15:0] trk, input logic last);
      req_type r;
      r.request_track = trk;
      r.last_request  = last;
      pending_reqs.push_back(r);
   endtask

   // A batch of random tracks, each with even odds of being clustered round the start track.
   task automatic queue_batch(input int n);
      logic [15:0] trk;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1)) trk = 16'($urandom_range(65535));
         else trk = 16'(start_shadow + $urandom_range(16) - 8);
         queue_req(trk, i == n - 1);
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = REG_MODE;
      csr_wdata = '0;
      mode_shadow  = MODE_FCFS;
      start_shadow = '0;
      error_count  = 0;
      transfer_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes in arrival order, a lone last item.
      queue_req(16'h0000, 1'b0);
      queue_req(16'hFFFF, 1'b0);
      queue_req(16'h5555, 1'b0);
      queue_req(16'hAAAA, 1'b1);
      queue_req(16'h1234, 1'b1);
      drain();
      // Nearest first with a tie on both sides of the head.
      write_reg(REG_MODE, 16'(MODE_SSTF));
      write_reg(REG_START, 16'd100);
      queue_req(16'd110, 1'b0);
      queue_req(16'd90, 1'b0);
      queue_req(16'd100, 1'b0);
      queue_req(16'd110, 1'b0);
      queue_req(16'd200, 1'b1);
      drain();
      // Elevator with tracks equal to the start and at both ends.
      write_reg(REG_MODE, 16'(MODE_SCAN));
      queue_req(16'd100, 1'b0);
      queue_req(16'hFFFF, 1'b0);
      queue_req(16'd0, 1'b0);
      queue_req(16'd101, 1'b0);
      queue_req(16'd99, 1'b1);
      drain();
      // Circular elevator from the top of the disk: everything wraps.
      write_reg(REG_MODE, 16'(MODE_CSCAN));
      write_reg(REG_START, 16'hFFFF);
      queue_req(16'd7, 1'b0);
      queue_req(16'hFFFF, 1'b0);
      queue_req(16'd3, 1'b1);
      drain();

      // Random phases over all modes and start extremes, with an overfull batch now and then.
      for (int p = 0; p < 12; p++) begin
         write_reg(REG_MODE, 16'(p % 4));
         write_reg(REG_START, (p % 6 == 1) ? 16'h0000 :
                              (p % 6 == 4) ? 16'hFFFF : 16'($urandom_range(65535)));
         for (int b = 0; b < 2; b++) begin
            if ((p == 5 || p == 10) && b == 0) queue_batch(DEPTH + 1 + $urandom_range(3));
            else queue_batch(1 + $urandom_range(6));
         end
         drain();
      end

      if (error_count == 0 && awaited_order.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/dss_pkg.sv
hdl/dss_cell.sv
hdl/disk_seek_scheduler.sv
tb/tb_top.sv
